// ===== sv/keyframe_joint_interpolator_assert.svh =====
// Assertion macros shared by the keyframe interpolator modules.
`ifndef KEYFRAME_JOINT_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_JOINT_INTERPOLATOR_ASSERT_SVH

// Checked on every clock edge outside reset.
`define KJI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define KJI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/kji_pkg.sv =====
// Package with the types, sizes and command codes of the keyframe interpolator.
package kji_pkg;

  localparam int NUM_JOINTS  = 32;
  localparam int MAX_POSES   = 32;
  localparam int NUM_MOTIONS = 8;

  localparam int JOINT_W  = $clog2(NUM_JOINTS);
  localparam int POSE_W   = $clog2(MAX_POSES);
  localparam int MOTION_W = $clog2(NUM_MOTIONS);
  localparam int ANGLE_AW = MOTION_W + POSE_W + JOINT_W;
  localparam int IVAL_AW  = MOTION_W + POSE_W;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_PAUSE     = 3'd3,
    CMD_LOAD_ANG  = 3'd4,
    CMD_LOAD_IVAL = 3'd5,
    CMD_LOAD_CNT  = 3'd6,
    CMD_SET_CUR   = 3'd7
  } kji_cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_param;
    logic load_diff;
    logic load_mul;
    logic load_div;
    logic div_step;
    logic emit;
    logic next_joint;
    logic finish;
  } kji_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tick_go;
    logic div_last;
    logic out_free;
    logic last_joint;
  } kji_sts_t;

endpackage

// ===== sv/kji_ctrl.sv =====
// Controller state machine that sequences commands and per-joint interpolation.
`include "keyframe_joint_interpolator_assert.svh"
module kji_ctrl
  import kji_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  input  kji_sts_t sts_i,
  output kji_ctl_t ctl_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PARAM = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_DIFF  = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_SIGN  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        ctl_o.accept = s_valid_i;
        if (s_valid_i && sts_i.tick_go) begin
          state_d = S_PARAM;
        end
      end
      S_PARAM: begin
        ctl_o.load_param = 1'b1;
        state_d          = S_READ;
      end
      S_READ: begin
        // The pose store output is registered and answers in the cycle after the joint index settles.
        state_d = S_DIFF;
      end
      S_DIFF: begin
        ctl_o.load_diff = 1'b1;
        state_d         = S_MUL;
      end
      S_MUL: begin
        ctl_o.load_mul = 1'b1;
        state_d        = S_SIGN;
      end
      S_SIGN: begin
        ctl_o.load_div = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        ctl_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          if (sts_i.last_joint) begin
            ctl_o.finish = 1'b1;
            state_d      = S_IDLE;
          end else begin
            ctl_o.next_joint = 1'b1;
            state_d          = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `KJI_ASSERT(a_div_to_out, (state_q == S_DIV && sts_i.div_last) |=> (state_q == S_OUT), "division did not end in the output state")
  `KJI_ASSERT(a_last_frees_input, (ctl_o.emit && sts_i.last_joint) |=> s_ready_o, "input not ready after the last word of a tick")
  `KJI_ASSERT(a_cmd_one_cycle, (ctl_o.accept && !sts_i.tick_go) |=> s_ready_o, "a command without output held the input")

endmodule

// ===== sv/kji_datapath.sv =====
// Datapath: pose stores, play state, interpolation multiplier, divider and output register.
`include "keyframe_joint_interpolator_assert.svh"
module kji_datapath
  import kji_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  kji_ctl_t    ctl_i,
  output kji_sts_t    sts_o,
  input  logic [2:0]  s_tuser_i,
  input  logic [47:0] s_tdata_i,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        m_tready_i,
  output logic        m_tvalid_o,
  output logic [23:0] m_tdata_o,
  output logic        m_tlast_o
);

  kji_cmd_e              cmd;
  logic [MOTION_W-1:0]   in_motion;
  logic [POSE_W-1:0]     in_pose;
  logic [JOINT_W-1:0]    in_joint;
  logic [15:0]           in_angle;
  logic [15:0]           in_value;

  assign cmd       = kji_cmd_e'(s_tuser_i);
  assign in_motion = s_tdata_i[2:0];
  assign in_pose   = s_tdata_i[7:3];
  assign in_joint  = s_tdata_i[12:8];
  assign in_angle  = s_tdata_i[28:13];
  assign in_value  = s_tdata_i[44:29];

  // Play state and small stores.
  logic                playing_q;
  logic [MOTION_W-1:0] motion_q;
  logic [5:0]          pose_q;
  logic [15:0]         step_q;
  logic [5:0]          active_q;
  logic [5:0]          counts_q [NUM_MOTIONS];
  logic [15:0]         start_q  [NUM_JOINTS];

  // Per-tick and per-joint working registers.
  logic [15:0]          n_q;
  logic [16:0]          kp1_q;
  logic [JOINT_W-1:0]   joint_q;
  logic [15:0]          s_q;
  logic [16:0]          diff_q;
  logic [33:0]          prod_q;
  logic                 neg_q;
  logic [15:0]          rem_q;
  logic [15:0]          dvd_q;
  logic [3:0]           div_cnt_q;
  logic                 out_valid_q;
  logic [23:0]          out_data_q;
  logic                 out_last_q;

  // Memories.
  logic [15:0] angle_mem [2**ANGLE_AW];
  logic [15:0] ival_mem  [2**IVAL_AW];
  logic [15:0] rd_e_q, rd_s_q, rd_ival_q;
  logic [ANGLE_AW-1:0] e_addr, s_addr, ang_waddr;
  logic [IVAL_AW-1:0]  ival_raddr, ival_waddr;
  logic [POSE_W-1:0]   prev_pose;

  assign prev_pose  = pose_q[POSE_W-1:0] - POSE_W'(1);
  assign e_addr     = {motion_q, pose_q[POSE_W-1:0], joint_q};
  assign s_addr     = {motion_q, prev_pose, joint_q};
  assign ang_waddr  = {in_motion, in_pose, in_joint};
  assign ival_raddr = {motion_q, pose_q[POSE_W-1:0]};
  assign ival_waddr = {in_motion, in_pose};

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept && cmd == CMD_LOAD_ANG) begin
      angle_mem[ang_waddr] <= in_angle;
    end
    rd_e_q <= angle_mem[e_addr];
    rd_s_q <= angle_mem[s_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept && cmd == CMD_LOAD_IVAL) begin
      ival_mem[ival_waddr] <= in_value;
    end
    rd_ival_q <= ival_mem[ival_raddr];
  end

  logic pose_ok;
  assign pose_ok = (pose_q < counts_q[motion_q]);

  // Joints per tick: zero counts as one, the count saturates at the joint total.
  logic [5:0]         nj;
  logic [JOINT_W-1:0] last_idx;
  always_comb begin
    if (active_q == 6'd0) begin
      nj = 6'd1;
    end else if (active_q > 6'(NUM_JOINTS)) begin
      nj = 6'(NUM_JOINTS);
    end else begin
      nj = active_q;
    end
  end
  assign last_idx = JOINT_W'(nj - 6'd1);

  logic step_wrap;
  assign step_wrap = (step_q >= n_q - 16'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= 1'b0;
      motion_q  <= '0;
      pose_q    <= '0;
      step_q    <= '0;
    end else if (ctl_i.accept) begin
      case (cmd)
        CMD_TICK: begin
          if (playing_q && !pose_ok) begin
            playing_q <= 1'b0;
            motion_q  <= '0;
            pose_q    <= '0;
            step_q    <= '0;
          end
        end
        CMD_START: begin
          playing_q <= 1'b1;
          motion_q  <= in_motion;
          pose_q    <= '0;
          step_q    <= '0;
        end
        CMD_STOP: begin
          playing_q <= 1'b0;
          motion_q  <= '0;
          pose_q    <= '0;
          step_q    <= '0;
        end
        CMD_PAUSE: begin
          playing_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end else if (ctl_i.finish) begin
      if (step_wrap) begin
        step_q <= '0;
        pose_q <= pose_q + 6'd1;
      end else begin
        step_q <= step_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 6'(NUM_JOINTS);
      for (int i = 0; i < NUM_MOTIONS; i++) begin
        counts_q[i] <= '0;
      end
      for (int i = 0; i < NUM_JOINTS; i++) begin
        start_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (ctl_i.accept && cmd == CMD_LOAD_CNT) begin
        counts_q[in_motion] <= (in_value > 16'(MAX_POSES)) ? 6'(MAX_POSES) : in_value[5:0];
      end
      if (ctl_i.accept && cmd == CMD_SET_CUR) begin
        start_q[in_joint] <= in_angle;
      end
    end
  end

  // Interval of the pose, with zero read as one, and the clamped step.
  logic [15:0] n_val, n_m1, k_val;
  assign n_val = (rd_ival_q == 16'd0) ? 16'd1 : rd_ival_q;
  assign n_m1  = n_val - 16'd1;
  assign k_val = (step_q >= n_m1) ? n_m1 : step_q;

  logic [15:0] s_val;
  assign s_val = (pose_q == 6'd0) ? start_q[joint_q] : rd_s_q;

  logic signed [34:0] prod;
  assign prod = $signed(diff_q) * $signed({1'b0, kp1_q});

  logic [33:0] mag;
  assign mag = prod_q[33] ? (34'd0 - prod_q) : prod_q;

  logic [16:0] trial;
  logic        q_bit;
  logic [16:0] trial_sub;
  assign trial     = {rem_q, dvd_q[15]};
  assign q_bit     = (trial >= {1'b0, n_q});
  assign trial_sub = trial - {1'b0, n_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      joint_q   <= '0;
      div_cnt_q <= '0;
    end else begin
      if (ctl_i.load_param) begin
        joint_q <= '0;
      end else if (ctl_i.next_joint) begin
        joint_q <= joint_q + JOINT_W'(1);
      end
      if (ctl_i.load_div) begin
        div_cnt_q <= '0;
      end else if (ctl_i.div_step) begin
        div_cnt_q <= div_cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_param) begin
      n_q   <= n_val;
      kp1_q <= {1'b0, k_val} + 17'd1;
    end
    if (ctl_i.load_diff) begin
      s_q    <= s_val;
      diff_q <= {rd_e_q[15], rd_e_q} - {s_val[15], s_val};
    end
    if (ctl_i.load_mul) begin
      prod_q <= prod[33:0];
    end
    // The quotient magnitude stays below 2^16, so the upper half starts below n.
    if (ctl_i.load_div) begin
      neg_q <= prod_q[33];
      rem_q <= mag[31:16];
      dvd_q <= mag[15:0];
    end else if (ctl_i.div_step) begin
      rem_q <= q_bit ? trial_sub[15:0] : trial[15:0];
      dvd_q <= {dvd_q[14:0], q_bit};
    end
  end

  // The target is s plus x/n, truncated toward zero as a whole.
  logic signed [17:0] q_signed, sum, target;
  assign q_signed = neg_q ? -$signed({2'b00, dvd_q}) : $signed({2'b00, dvd_q});
  assign sum      = $signed({{2{s_q[15]}}, s_q}) + q_signed;
  always_comb begin
    target = sum;
    if (rem_q != 16'd0) begin
      if (!neg_q && sum < 0) begin
        target = sum + 18'sd1;
      end else if (neg_q && sum > 0) begin
        target = sum - 18'sd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      out_data_q <= {3'b000, target[15:0], joint_q};
      out_last_q <= (joint_q == last_idx);
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;

  assign sts_o.tick_go    = (cmd == CMD_TICK) && playing_q && pose_ok;
  assign sts_o.div_last   = (div_cnt_q == 4'd15);
  assign sts_o.out_free   = !out_valid_q || m_tready_i;
  assign sts_o.last_joint = (joint_q == last_idx);

  `KJI_ASSERT(a_rem_below_n, ctl_i.emit |-> (rem_q < n_q), "division remainder not below the interval")
  `KJI_ASSERT(a_step_in_range, ctl_i.load_param |=> (kp1_q != 17'd0 && kp1_q <= {1'b0, n_q}), "step outside the pose interval")
  `KJI_ASSERT_ALWAYS(a_no_word_in_reset, !rst_ni |=> !out_valid_q, "output word valid during reset")

endmodule

// ===== sv/keyframe_joint_interpolator.sv =====
// Top level of the keyframe joint interpolator.
// Usage: every input word carries one command in s_axis_tuser; s_axis_tdata holds
// motion, pose, joint, angle and value. Loads, start, stop and pause produce
// nothing. A tick while playing, with the pose below its motion's pose count,
// produces one output word per active joint (joint index and interpolated
// angle), tlast on the last joint of the tick. Each joint steps through read,
// difference, multiply, sign, the 16-step serial divider (one quotient bit per
// cycle) and the output state, which waits for a free output register. The next
// input word is taken once the last word of the tick sits in the output register.
// A stalled receiver holds the output word and, after it, the whole block.
// The user must write the active joint count through cfg_we_i/cfg_wdata_i only
// while idle; the block does not enforce this. Reset stops playback, sets pose
// counts, starting pose and play position to zero and the active joint count
// to 32; pose angles and intervals hold nothing until loaded (no clearing pass).
module keyframe_joint_interpolator
  import kji_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // motion_id[2:0], pose_index[7:3], joint_index[12:8], angle[28:13], value[44:29]
  input  logic [47:0] s_axis_tdata,
  // command[2:0]
  input  logic [2:0]  s_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // target_joint[4:0], target_angle[20:5]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  kji_ctl_t ctl;
  kji_sts_t sts;

  kji_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  kji_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .s_tuser_i   (s_axis_tuser),
    .s_tdata_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tlast_o   (m_axis_tlast)
  );

endmodule
